>>> sv/diameter_result_code_extractor_defines.svh
// Assertion helpers shared by the RTL.
`ifndef DIAMETER_RESULT_CODE_EXTRACTOR_DEFINES_SVH
`define DIAMETER_RESULT_CODE_EXTRACTOR_DEFINES_SVH

// Check a property on every rising clock edge outside of reset.
`define DRCE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on any rising clock edge outside of reset.
`define DRCE_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> sv/drce_pkg.sv
`default_nettype none
package drce_pkg;

	localparam int POS_BITS = 24;
	localparam int ADDR_W   = 4;

	localparam logic [7:0]  HEADER_BYTES_RST  = 8'd20;
	localparam logic [31:0] RESULT_CODE_RST   = 32'd268;
	localparam logic [31:0] EXPER_CODE_RST    = 32'd297;
	localparam logic [7:0]  EXPER_SKIP_RST    = 8'd20;

	localparam logic [1:0] REG_HEADER_BYTES = 2'd0;
	localparam logic [1:0] REG_RESULT_CODE  = 2'd1;
	localparam logic [1:0] REG_EXPER_CODE   = 2'd2;
	localparam logic [1:0] REG_EXPER_SKIP   = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic        from_experimental;
		logic [31:0] result_value;
		logic        malformed;
	} result_t;

	typedef struct packed {
		logic [7:0]  header_bytes;
		logic [31:0] result_code_id;
		logic [31:0] experimental_code_id;
		logic [7:0]  experimental_skip;
	} cfg_t;

endpackage
`default_nettype wire

>>> sv/drce_regs.sv
`default_nettype none
module drce_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [drce_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output drce_pkg::cfg_t                   cfg
);
	import drce_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_bytes         <= HEADER_BYTES_RST;
			cfg_q.result_code_id       <= RESULT_CODE_RST;
			cfg_q.experimental_code_id <= EXPER_CODE_RST;
			cfg_q.experimental_skip    <= EXPER_SKIP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HEADER_BYTES: cfg_q.header_bytes         <= pwdata[7:0];
				REG_RESULT_CODE:  cfg_q.result_code_id       <= pwdata;
				REG_EXPER_CODE:   cfg_q.experimental_code_id <= pwdata;
				REG_EXPER_SKIP:   cfg_q.experimental_skip    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HEADER_BYTES: prdata = {24'd0, cfg_q.header_bytes};
			REG_RESULT_CODE:  prdata = cfg_q.result_code_id;
			REG_EXPER_CODE:   prdata = cfg_q.experimental_code_id;
			REG_EXPER_SKIP:   prdata = {24'd0, cfg_q.experimental_skip};
			default:          prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> sv/drce_parser.sv
`default_nettype none
module drce_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire drce_pkg::in_item_t item,
	input  wire drce_pkg::cfg_t    cfg,
	output drce_pkg::result_t      res
);
	import drce_pkg::*;

	localparam int SUM_W = 26;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	localparam logic [1:0] PH_WALK  = 2'd0;
	localparam logic [1:0] PH_VALUE = 2'd1;
	localparam logic [1:0] PH_END   = 2'd2;

	function automatic logic [POS_BITS-1:0] clamp_pos(input logic [SUM_W-1:0] v);
		logic [POS_BITS-1:0] r;
		if (v > SUM_W'(POS_MAX)) r = POS_MAX;
		else r = v[POS_BITS-1:0];
		return r;
	endfunction

	logic [POS_BITS-1:0] pos_q, nas_q, vp_q;
	logic [31:0]         fs_q, code_q;
	logic [1:0]          ph_q;
	logic                exp_q, found_q, malf_q;

	// state as seen by this byte: a message start restarts the walk
	logic                at_start;
	logic [POS_BITS-1:0] nas_c, vp_c;
	logic [31:0]         fs_c, code_c;
	logic [1:0]          ph_c;
	logic                exp_c, found_c, malf_c;

	logic [POS_BITS-1:0] pos_n, nas_n, vp_n;
	logic [31:0]         fs_n, code_n;
	logic [1:0]          ph_n;
	logic                exp_n, found_n, malf_n;

	logic [31:0]         fs_shift;
	logic [23:0]         avp_len;
	logic [24:0]         padded;
	logic [POS_BITS-1:0] walk_diff, val_diff;
	logic                walk_hit, val_hit;
	logic [2:0]          woff;
	logic [1:0]          voff;

	assign at_start = (pos_q == '0);
	assign nas_c    = at_start ? POS_BITS'(cfg.header_bytes) : nas_q;
	assign vp_c     = at_start ? '0 : vp_q;
	assign fs_c     = at_start ? 32'd0 : fs_q;
	assign code_c   = at_start ? 32'd0 : code_q;
	assign ph_c     = at_start ? PH_WALK : ph_q;
	assign exp_c    = at_start ? 1'b0 : exp_q;
	assign found_c  = at_start ? 1'b0 : found_q;
	assign malf_c   = at_start ? 1'b0 : malf_q;

	assign fs_shift  = {fs_c[23:0], item.data_byte};
	assign avp_len   = fs_shift[23:0];
	assign padded    = ({1'b0, avp_len} + 25'd3) & ~25'd3;
	assign walk_diff = pos_q - nas_c;
	assign val_diff  = pos_q - vp_c;
	assign walk_hit  = (pos_q >= nas_c) && (walk_diff[POS_BITS-1:3] == '0);
	assign val_hit   = (pos_q >= vp_c) && (val_diff[POS_BITS-1:2] == '0);
	assign woff      = walk_diff[2:0];
	assign voff      = val_diff[1:0];

	always_comb begin
		nas_n   = nas_c;
		vp_n    = vp_c;
		fs_n    = fs_c;
		code_n  = code_c;
		ph_n    = ph_c;
		exp_n   = exp_c;
		found_n = found_c;
		malf_n  = malf_c;
		if (pos_q == POS_MAX) begin
			ph_n = PH_END;
		end else begin
			case (ph_c)
				PH_WALK: begin
					if (walk_hit && woff != 3'd4) begin
						fs_n = fs_shift;
						if (woff == 3'd3) begin
							code_n = fs_shift;
							fs_n   = 32'd0;
						end else if (woff == 3'd7) begin
							fs_n = 32'd0;
							if (code_c == cfg.result_code_id) begin
								vp_n = clamp_pos(SUM_W'(nas_c) + SUM_W'(8));
								ph_n = PH_VALUE;
							end else if (code_c == cfg.experimental_code_id) begin
								vp_n  = clamp_pos(SUM_W'(nas_c) + SUM_W'(8)
									+ SUM_W'(cfg.experimental_skip));
								exp_n = 1'b1;
								ph_n  = PH_VALUE;
							end else if (avp_len < 24'd8) begin
								malf_n = 1'b1;
								ph_n   = PH_END;
							end else begin
								nas_n = clamp_pos(SUM_W'(nas_c) + SUM_W'(padded));
							end
						end
					end
				end
				PH_VALUE: begin
					if (val_hit) begin
						fs_n = fs_shift;
						if (voff == 2'd3) begin
							found_n = 1'b1;
							ph_n    = PH_END;
						end
					end
				end
				default: ;
			endcase
		end
		if (item.last_byte) pos_n = '0;
		else if (pos_q == POS_MAX) pos_n = pos_q;
		else pos_n = pos_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ph_q    <= PH_WALK;
			exp_q   <= 1'b0;
			found_q <= 1'b0;
			malf_q  <= 1'b0;
		end else if (step) begin
			pos_q   <= pos_n;
			ph_q    <= ph_n;
			exp_q   <= exp_n;
			found_q <= found_n;
			malf_q  <= malf_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			nas_q  <= nas_n;
			vp_q   <= vp_n;
			fs_q   <= fs_n;
			code_q <= code_n;
		end
	end

	assign res.found             = found_n;
	assign res.from_experimental = found_n && exp_n;
	assign res.result_value      = found_n ? fs_n : 32'd0;
	assign res.malformed         = malf_n;

endmodule
`default_nettype wire

>>> sv/diameter_result_code_extractor.sv
// Diameter Result-Code extractor.
// Message bytes enter on the byte channel (byte_valid / byte_ready, payload
// byte_item with data_byte and last_byte). One result leaves on the result
// channel (result_valid / result_ready, payload result_item) for each byte
// marked last_byte; no other byte yields a transfer.
// The APB port sets header length, the two AVP codes and the experimental
// skip; write it only between messages. pready is tied high.
// Throughput: one byte per cycle unless a last byte stalls, as below. Each
// byte passes an input register, then the compare and position update into
// the parser state. The result of a last byte is then taken into the output
// register; the last byte waits while an earlier result still waits there.
// The output register lets the next message stream in while a result waits;
// only a further last byte stalls (byte_ready low) until result_ready.
// Reset (arst_n low) empties both registers, restores the configuration
// defaults and restarts the walk at byte position zero.
`default_nettype none
`include "diameter_result_code_extractor_defines.svh"
module diameter_result_code_extractor (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        byte_valid,
	output logic                             byte_ready,
	input  wire drce_pkg::in_item_t          byte_item,
	output logic                             result_valid,
	input  wire logic                        result_ready,
	output drce_pkg::result_t                result_item,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [drce_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);
	import drce_pkg::*;

	cfg_t     cfg;
	result_t  res;
	in_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	logic     result_valid_q;
	result_t  result_item_q;

	drce_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	drce_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// a last byte waits while the result register is still full and not being read
	assign advance    = valid_s1 && (!item_s1.last_byte || !result_valid_q || result_ready);
	assign byte_ready = !valid_s1 || advance;
	assign pready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) item_s1 <= byte_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) result_item_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_item_q;

	`DRCE_ASSERT(a_last_blocks,
		(valid_s1 && item_s1.last_byte && result_valid_q && !result_ready) |-> !byte_ready,
		"last byte advanced over a full result register")
	`DRCE_NEVER(a_exp_needs_found,
		result_valid_q && result_item_q.from_experimental && !result_item_q.found,
		"experimental flag without found")
	`DRCE_ASSERT(a_zero_not_found,
		(result_valid_q && !result_item_q.found) |-> (result_item_q.result_value == 32'd0),
		"nonzero value on not found")

endmodule
`default_nettype wire
